// ===== rtl/core/kmer_histogram_counter_macros.svh =====
// ----------------------------------------------------------------------------
// kmer_histogram_counter assertion macros
// Implication checks used by the block's monitor.
// ----------------------------------------------------------------------------
`ifndef KMER_HISTOGRAM_COUNTER_MACROS_SVH
`define KMER_HISTOGRAM_COUNTER_MACROS_SVH

// same-cycle implication
`define KHC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/kmhc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmhc_pkg
// Shared types, codes and base decoding for the k-mer histogram counter.
// ----------------------------------------------------------------------------
`default_nettype none

package kmhc_pkg;

   localparam int SLOT_BITS      = 32;  // widest table index (k up to 16)
   localparam int INDEX_BITS     = 16;
   localparam int CHAR_BITS      = 8;
   localparam int KLEN_BITS      = 4;
   localparam int COUNT_OUT_BITS = 32;
   localparam int TOTAL_BITS     = 48;

   localparam logic [KLEN_BITS-1:0]  KMER_LENGTH_RESET = 4'd4;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX         = {TOTAL_BITS{1'b1}};

   localparam logic OP_BASE = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   localparam logic [CHAR_BITS-1:0] CHAR_A_UP = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_C_UP = 8'h43;
   localparam logic [CHAR_BITS-1:0] CHAR_G_UP = 8'h47;
   localparam logic [CHAR_BITS-1:0] CHAR_T_UP = 8'h54;
   localparam logic [CHAR_BITS-1:0] CHAR_A_LO = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_C_LO = 8'h63;
   localparam logic [CHAR_BITS-1:0] CHAR_G_LO = 8'h67;
   localparam logic [CHAR_BITS-1:0] CHAR_T_LO = 8'h74;

   typedef struct packed {
      logic                  op;
      logic [CHAR_BITS-1:0]  base_char;
      logic                  read_start;
      logic [INDEX_BITS-1:0] entry_index;
   } kmhc_req_type;

   typedef struct packed {
      logic                      kmer_valid;
      logic [INDEX_BITS-1:0]     kmer_index;
      logic [COUNT_OUT_BITS-1:0] entry_count;
      logic                      bad_base;
      logic [TOTAL_BITS-1:0]     running_total;
   } kmhc_rsp_type;

   // classified work item, front to back
   typedef struct packed {
      logic                  op_read;
      logic                  counted;
      logic                  bad_base;
      logic [INDEX_BITS-1:0] kmer_index;
      logic [SLOT_BITS-1:0]  slot;
   } kmhc_item_type;

   typedef struct packed {
      logic          valid;
      kmhc_item_type item;
   } kmhc_head_type;

   typedef struct packed {
      logic       bad;
      logic [1:0] code;
   } kmhc_base_type;

   function automatic kmhc_base_type decode_base(input logic [CHAR_BITS-1:0] ch);
      kmhc_base_type res;
      res.bad  = 1'b0;
      res.code = CODE_A;
      unique case (ch)
         CHAR_A_UP, CHAR_A_LO: res.code = CODE_A;
         CHAR_C_UP, CHAR_C_LO: res.code = CODE_C;
         CHAR_G_UP, CHAR_G_LO: res.code = CODE_G;
         CHAR_T_UP, CHAR_T_LO: res.code = CODE_T;
         default:              res.bad  = 1'b1;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kmhc_ram.sv =====
// ----------------------------------------------------------------------------
// kmhc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kmhc_ram #(
   parameter int          WIDTH = 32,
   parameter longint      DEPTH = 65536
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/kmhc_front.sv =====
// ----------------------------------------------------------------------------
// kmhc_front
// Holds k and the base window; classifies each accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module kmhc_front #(
   parameter int MAX_K = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [kmhc_pkg::KLEN_BITS-1:0]     csr_write_data,
   input  wire logic                               take,
   input  wire kmhc_pkg::kmhc_req_type             req_data,
   output kmhc_pkg::kmhc_item_type                 item
);

   localparam int WIN_BITS  = 2 * MAX_K;
   localparam int FILL_BITS = $clog2(MAX_K + 1);

   logic [kmhc_pkg::KLEN_BITS-1:0] kmer_length_ff;
   logic [WIN_BITS-1:0]            window_ff, window_in;
   logic [FILL_BITS-1:0]           fill_ff, fill_in;

   kmhc_pkg::kmhc_base_type        dec;
   logic [WIN_BITS-1:0]            win_base, win_shift, kmask, masked;
   logic [WIN_BITS+1:0]            win_cat;
   logic [FILL_BITS-1:0]           fill_base, fill_next;
   logic [4:0]                     k_eff;
   logic [kmhc_pkg::SLOT_BITS-1:0] masked_ext;

   always_comb begin
      dec       = kmhc_pkg::decode_base(req_data.base_char);
      win_base  = req_data.read_start ? '0 : window_ff;
      fill_base = req_data.read_start ? '0 : fill_ff;
      win_cat   = {win_base, dec.code};
      win_shift = win_cat[WIN_BITS-1:0];
      fill_next = (fill_base < FILL_BITS'(MAX_K)) ? fill_base + FILL_BITS'(1) : fill_base;

      // zero acts as one, anything above MAX_K as MAX_K
      if (kmer_length_ff == '0) begin
         k_eff = 5'd1;
      end else if ({1'b0, kmer_length_ff} > 5'(MAX_K)) begin
         k_eff = 5'(MAX_K);
      end else begin
         k_eff = {1'b0, kmer_length_ff};
      end

      for (int i = 0; i < MAX_K; i++) begin
         kmask[2*i +: 2] = (5'(i) < k_eff) ? 2'b11 : 2'b00;
      end
      masked     = win_shift & kmask;
      masked_ext = kmhc_pkg::SLOT_BITS'(masked);

      item       = '0;
      window_in  = window_ff;
      fill_in    = fill_ff;
      if (req_data.op == kmhc_pkg::OP_READ) begin
         item.op_read    = 1'b1;
         item.kmer_index = req_data.entry_index;
         item.slot       = kmhc_pkg::SLOT_BITS'(req_data.entry_index);
      end else if (dec.bad) begin
         item.bad_base = 1'b1;
         window_in     = '0;
         fill_in       = '0;
      end else begin
         item.kmer_index = masked_ext[kmhc_pkg::INDEX_BITS-1:0];
         item.slot       = masked_ext;
         item.counted    = (5'(fill_next) >= k_eff);
         window_in       = win_shift;
         fill_in         = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= kmhc_pkg::KMER_LENGTH_RESET;
         window_ff      <= '0;
         fill_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            kmer_length_ff <= csr_write_data;
         end
         if (take) begin
            window_ff <= window_in;
            fill_ff   <= fill_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/kmhc_queue.sv =====
// ----------------------------------------------------------------------------
// kmhc_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module kmhc_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire kmhc_pkg::kmhc_item_type   push_item,
   input  wire logic                      pop,
   output logic                           full,
   output kmhc_pkg::kmhc_head_type        head
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   kmhc_pkg::kmhc_item_type entry_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]     count_ff;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + CNT_BITS'(1);
            2'b01:   count_ff <= count_ff - CNT_BITS'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/kmhc_back.sv =====
// ----------------------------------------------------------------------------
// kmhc_back
// Histogram read-modify-write with forwarding, running total, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmhc_back #(
   parameter int MAX_K      = 8,
   parameter int COUNT_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire kmhc_pkg::kmhc_head_type   head,
   output logic                           pop,
   output logic                           clearing,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output kmhc_pkg::kmhc_rsp_type         rsp_data
);

   localparam int     ADDR_BITS = 2 * MAX_K;
   localparam longint DEPTH     = longint'(1) << ADDR_BITS;

   // sweep state
   logic                  clearing_ff;
   logic [ADDR_BITS-1:0]  clear_addr_ff;

   // lookup stage
   logic                    b1_valid_ff;
   kmhc_pkg::kmhc_item_type b1_item_ff;
   logic [ADDR_BITS-1:0]    b1_slot;

   // last write, for back-to-back hits
   logic                   fwd_valid_ff;
   logic [ADDR_BITS-1:0]   fwd_addr_ff;
   logic [COUNT_BITS-1:0]  fwd_data_ff;

   logic [kmhc_pkg::TOTAL_BITS-1:0] total_ff, total_in;
   logic                            rsp_valid_ff;
   kmhc_pkg::kmhc_rsp_type          rsp_ff;

   logic                   fire, wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0]  wr_data, rd_data, old_count, inc_count, sel_count;
   logic [63:0]            count_ext;

   kmhc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (pop),
      .rd_addr (head.item.slot[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      b1_slot   = b1_item_ff.slot[ADDR_BITS-1:0];
      fire      = b1_valid_ff && (!rsp_valid_ff || !rsp_stall);
      pop       = head.valid && !clearing_ff && (!b1_valid_ff || fire);
      old_count = (fwd_valid_ff && (fwd_addr_ff == b1_slot)) ? fwd_data_ff : rd_data;
      inc_count = (old_count == '1) ? old_count : old_count + COUNT_BITS'(1);

      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = fire && b1_item_ff.counted;
         wr_addr = b1_slot;
         wr_data = inc_count;
      end

      total_in = total_ff;
      if (fire && b1_item_ff.counted && (total_ff != kmhc_pkg::TOTAL_MAX)) begin
         total_in = total_ff + kmhc_pkg::TOTAL_BITS'(1);
      end

      if (b1_item_ff.counted) begin
         sel_count = inc_count;
      end else if (b1_item_ff.op_read) begin
         sel_count = old_count;
      end else begin
         sel_count = '0;
      end
      count_ext = 64'(sel_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         b1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + ADDR_BITS'(1);
            if (clear_addr_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end
         if (pop) begin
            b1_valid_ff <= 1'b1;
         end else if (fire) begin
            b1_valid_ff <= 1'b0;
         end
         if (fire && b1_item_ff.counted) begin
            fwd_valid_ff <= 1'b1;
         end
         total_ff     <= total_in;
         rsp_valid_ff <= fire || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_item_ff <= head.item;
      end
      if (fire && b1_item_ff.counted) begin
         fwd_addr_ff <= b1_slot;
         fwd_data_ff <= inc_count;
      end
      if (fire) begin
         rsp_ff.kmer_valid    <= b1_item_ff.counted;
         rsp_ff.kmer_index    <= b1_item_ff.kmer_index;
         rsp_ff.entry_count   <= count_ext[kmhc_pkg::COUNT_OUT_BITS-1:0];
         rsp_ff.bad_base      <= b1_item_ff.bad_base;
         rsp_ff.running_total <= total_in;
      end
   end

   assign clearing  = clearing_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/kmer_histogram_counter.sv =====
// ----------------------------------------------------------------------------
// kmer_histogram_counter
// Streams nucleotide characters, counts k-mers into a histogram table.
// ----------------------------------------------------------------------------
//
//   channel   direction  signals                          transfer when
//   req_      in         req_valid / req_stall / req_data  valid && !stall
//   rsp_      out        rsp_valid / rsp_stall / rsp_data  valid && !stall
//   csr_      in         csr_write_enable / csr_write_data write_enable high
//
// One request per cycle sustained while rsp_stall stays low; each result
// goes through front classify into queue, table read, result register.
// After reset the table is swept to zero, one entry per cycle, over all
// 2^(2*MAX_K) entries (65536 at default), with req_stall held high.
// req_stall rises when the 4-entry queue is full; rsp_stall backs up the
// lookup stage, then the queue. The table's single read port sets the rate.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_histogram_counter #(
   parameter int MAX_K      = 8,
   parameter int COUNT_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire kmhc_pkg::kmhc_req_type          req_data,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output kmhc_pkg::kmhc_rsp_type               rsp_data,
   // k register
   input  wire logic                            csr_write_enable,
   input  wire logic [kmhc_pkg::KLEN_BITS-1:0]  csr_write_data
);

   localparam int QUEUE_DEPTH = 4;

   logic                    take;
   logic                    q_full, q_pop, clearing;
   kmhc_pkg::kmhc_item_type item;
   kmhc_pkg::kmhc_head_type head;

   // no intake while the table sweep runs or the queue is full
   assign req_stall = clearing || q_full;
   assign take      = req_valid && !req_stall;

   // front: k register, window and fill; decides counted / bad / read
   kmhc_front #(
      .MAX_K (MAX_K)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .take             (take),
      .req_data         (req_data),
      .item             (item)
   );

   // decouples intake from the table pipeline
   kmhc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_item (item),
      .pop       (q_pop),
      .full      (q_full),
      .head      (head)
   );

   // back: table read, saturating increment with forwarding, total, output
   kmhc_back #(
      .MAX_K      (MAX_K),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/kmhc_monitor.sv =====
// ----------------------------------------------------------------------------
// kmhc_monitor
// Port-level checks on the k-mer histogram counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kmer_histogram_counter_macros.svh"

module kmhc_monitor (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_stall,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire kmhc_pkg::kmhc_rsp_type          rsp_data
);

   logic                            rsp_xfer;
   logic                            rsp_held;
   logic                            bad_clear;
   logic                            total_ok;
   logic [kmhc_pkg::TOTAL_BITS-1:0] last_total_ff;

   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign rsp_held  = rsp_valid && rsp_stall;
   assign bad_clear = (rsp_data.entry_count == '0) && (rsp_data.kmer_index == '0);

   // counted result moves the total up by one unless it sits at its ceiling
   assign total_ok = rsp_data.kmer_valid
      ? ((rsp_data.running_total == last_total_ff + kmhc_pkg::TOTAL_BITS'(1))
         || ((last_total_ff == kmhc_pkg::TOTAL_MAX)
             && (rsp_data.running_total == kmhc_pkg::TOTAL_MAX)))
      : (rsp_data.running_total == last_total_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_total_ff <= '0;
      end else if (rsp_xfer) begin
         last_total_ff <= rsp_data.running_total;
      end
   end

   `KHC_ASSERT_IMP(a_count_not_bad, clock, reset, rsp_xfer && rsp_data.kmer_valid, !rsp_data.bad_base, "counted k-mer flagged bad")

   `KHC_ASSERT_IMP(a_bad_zero, clock, reset, rsp_xfer && rsp_data.bad_base, bad_clear, "bad base result not cleared")

   `KHC_ASSERT_IMP(a_total_step, clock, reset, rsp_xfer, total_ok, "total out of step")

   `KHC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data), "stalled result changed")

   `KHC_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, req_stall && !rsp_valid, "not quiet after reset")

endmodule

bind kmer_histogram_counter kmhc_monitor u_monitor (.*);

`default_nettype wire
